// ===== rtl/qmj_pkg.sv =====
// shared types, constants and width helpers for the quintic coefficient block
`default_nettype none
package qmj_pkg;

    localparam int IN_W  = 32;
    localparam int T_W   = 20;
    localparam int OUT_W = 48;
    // quotient bits kept by each divider; more than this means clipping
    localparam int QB    = 49;

    typedef struct packed {
        logic signed [IN_W-1:0] start_pos;
        logic signed [IN_W-1:0] start_vel;
        logic signed [IN_W-1:0] start_acc;
        logic signed [IN_W-1:0] end_pos;
        logic signed [IN_W-1:0] end_vel;
        logic signed [IN_W-1:0] end_acc;
        logic [T_W-1:0]         duration;
    } t_qmj_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] coef0;
        logic signed [OUT_W-1:0] coef1;
        logic signed [OUT_W-1:0] coef2;
        logic signed [OUT_W-1:0] coef3;
        logic signed [OUT_W-1:0] coef4;
        logic signed [OUT_W-1:0] coef5;
        logic                    saturated;
    } t_qmj_out;

    typedef struct packed {
        logic                    sat;
        logic signed [OUT_W-1:0] q;
    } t_sat48;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_bk_state;

    function automatic int qmj_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // width of the combined residual terms for a given fraction width
    function automatic int qmj_mw(input int f);
        int rbiw;
        int raw;
        rbiw = qmj_max(33 + f, 53) + 1;
        raw  = qmj_max(qmj_max(34 + 2 * f, 54 + f), 74) + 2;
        return qmj_max(qmj_max(raw, rbiw + 21), 75) + 6;
    endfunction

    // clip a 64-bit value to the signed 48-bit output range
    function automatic t_sat48 sat48(input logic signed [63:0] v);
        t_sat48 r;
        if ((v[63:OUT_W-1] == '0) || (v[63:OUT_W-1] == '1)) begin
            r.sat = 1'b0;
            r.q   = v[OUT_W-1:0];
        end else begin
            r.sat = 1'b1;
            r.q   = v[63] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/qmj_fifo.sv =====
// small show-ahead queue between the front and the back
`default_nettype none
module qmj_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty,
    output logic              o_full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
endmodule
`default_nettype wire

// ===== rtl/qmj_front.sv =====
// front pipeline: residuals, numerators and powers of the duration
`default_nettype none
module qmj_front
    import qmj_pkg::*;
#(
    parameter int F  = 16,
    parameter int MW = 96
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire t_qmj_in        i_item,
    output logic                o_valid,
    output logic signed [OUT_W-1:0] o_c0,
    output logic signed [OUT_W-1:0] o_c1,
    output logic signed [OUT_W-1:0] o_c2,
    output logic                o_sat012,
    output logic                o_zero,
    output logic signed [MW-1:0] o_m3,
    output logic signed [MW-1:0] o_m4,
    output logic signed [MW-1:0] o_m5,
    output logic [3*T_W-1:0]    o_t3,
    output logic [4*T_W-1:0]    o_t4,
    output logic [5*T_W-1:0]    o_t5
);
    localparam int RBIW = qmj_max(33 + F, 53) + 1;
    localparam int RAW  = qmj_max(qmj_max(34 + 2 * F, 54 + F), 74) + 2;
    localparam int RBW  = RBIW + 21;
    localparam int HW   = 2 * T_W;

    logic [4:0] r_v;

    t_sat48 w_s0, w_s1, w_s2;

    // stage 1
    logic signed [32:0] r1_dp, r1_dv, r1_da;
    logic signed [52:0] r1_svt, r1_sat;
    logic [HW-1:0]      r1_t2;
    logic [T_W-1:0]     r1_t;
    logic signed [OUT_W-1:0] r1_c0, r1_c1, r1_c2;
    logic               r1_s, r1_z;
    // stage 2
    logic signed [73:0]     r2_satt;
    logic signed [RBIW-1:0] r2_rbi;
    logic signed [53:0]     r2_rc1;
    logic [3*T_W-1:0]       r2_t3;
    logic signed [32:0]     r2_dp;
    logic signed [52:0]     r2_svt;
    logic [T_W-1:0]         r2_t;
    logic signed [OUT_W-1:0] r2_c0, r2_c1, r2_c2;
    logic                   r2_s, r2_z;
    // stage 3
    logic signed [RAW-1:0] r3_ra;
    logic signed [RBW-1:0] r3_rb;
    logic signed [74:0]    r3_rc;
    logic [3*T_W-1:0]      r3_t3;
    logic [4*T_W-1:0]      r3_t4;
    logic [T_W-1:0]        r3_t;
    logic signed [OUT_W-1:0] r3_c0, r3_c1, r3_c2;
    logic                  r3_s, r3_z;
    // stage 4
    logic signed [MW-1:0]  r4_m3, r4_m4, r4_m5;
    logic [HW+T_W-1:0]     r4_lo, r4_hi;
    logic [3*T_W-1:0]      r4_t3;
    logic [4*T_W-1:0]      r4_t4;
    logic signed [OUT_W-1:0] r4_c0, r4_c1, r4_c2;
    logic                  r4_s, r4_z;
    // stage 5
    logic signed [MW-1:0]  r5_m3, r5_m4, r5_m5;
    logic [3*T_W-1:0]      r5_t3;
    logic [4*T_W-1:0]      r5_t4;
    logic [5*T_W-1:0]      r5_t5;
    logic signed [OUT_W-1:0] r5_c0, r5_c1, r5_c2;
    logic                  r5_s, r5_z;

    logic signed [T_W:0] w_ts;
    logic signed [MW-1:0] w_ra, w_rb, w_rc, w_d;

    always_comb begin
        w_ts = $signed({1'b0, i_item.duration});
        w_s0 = sat48(64'(i_item.start_pos) <<< (32 - F));
        w_s1 = sat48(64'(i_item.start_vel) <<< (32 - F));
        w_s2 = sat48(64'(i_item.start_acc) <<< (31 - F));
        w_ra = MW'(r3_ra);
        w_rb = MW'(r3_rb);
        w_rc = MW'(r3_rc);
        w_d  = w_ra - w_rb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_take};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dp  <= 33'(i_item.end_pos) - 33'(i_item.start_pos);
        r1_dv  <= 33'(i_item.end_vel) - 33'(i_item.start_vel);
        r1_da  <= 33'(i_item.end_acc) - 33'(i_item.start_acc);
        r1_svt <= 53'(i_item.start_vel) * 53'(w_ts);
        r1_sat <= 53'(i_item.start_acc) * 53'(w_ts);
        r1_t2  <= HW'(i_item.duration) * HW'(i_item.duration);
        r1_t   <= i_item.duration;
        r1_c0  <= w_s0.q;
        r1_c1  <= w_s1.q;
        r1_c2  <= w_s2.q;
        r1_s   <= w_s0.sat | w_s1.sat | w_s2.sat;
        r1_z   <= (i_item.duration == '0);

        r2_satt <= 74'(r1_sat) * 74'($signed({1'b0, r1_t}));
        r2_rbi  <= (RBIW'(r1_dv) <<< F) - RBIW'(r1_sat);
        r2_rc1  <= 54'(r1_da) * 54'($signed({1'b0, r1_t}));
        r2_t3   <= (3*T_W)'(r1_t2) * (3*T_W)'(r1_t);
        r2_dp   <= r1_dp;
        r2_svt  <= r1_svt;
        r2_t    <= r1_t;
        r2_c0   <= r1_c0;
        r2_c1   <= r1_c1;
        r2_c2   <= r1_c2;
        r2_s    <= r1_s;
        r2_z    <= r1_z;

        r3_ra <= (RAW'(r2_dp) <<< (2 * F + 1)) - (RAW'(r2_svt) <<< (F + 1)) - RAW'(r2_satt);
        r3_rb <= RBW'(r2_rbi) * RBW'($signed({1'b0, r2_t}));
        r3_rc <= 75'(r2_rc1) * 75'($signed({1'b0, r2_t}));
        r3_t4 <= (4*T_W)'(r2_t3) * (4*T_W)'(r2_t);
        r3_t3 <= r2_t3;
        r3_t  <= r2_t;
        r3_c0 <= r2_c0;
        r3_c1 <= r2_c1;
        r3_c2 <= r2_c2;
        r3_s  <= r2_s;
        r3_z  <= r2_z;

        // 10 ra - 8 rb + rc, 14 rb - 15 ra - 2 rc, 6 (ra - rb) + rc
        r4_m3 <= (w_ra <<< 3) + (w_ra <<< 1) - (w_rb <<< 3) + w_rc;
        r4_m4 <= (w_rb <<< 4) - (w_rb <<< 1) - ((w_ra <<< 4) - w_ra) - (w_rc <<< 1);
        r4_m5 <= (w_d <<< 2) + (w_d <<< 1) + w_rc;
        // t^5 in two partial products
        r4_lo <= (HW+T_W)'(r3_t4[HW-1:0]) * (HW+T_W)'(r3_t);
        r4_hi <= (HW+T_W)'(r3_t4[4*T_W-1:HW]) * (HW+T_W)'(r3_t);
        r4_t3 <= r3_t3;
        r4_t4 <= r3_t4;
        r4_c0 <= r3_c0;
        r4_c1 <= r3_c1;
        r4_c2 <= r3_c2;
        r4_s  <= r3_s;
        r4_z  <= r3_z;

        r5_t5 <= (5*T_W)'(r4_lo) + ((5*T_W)'(r4_hi) << HW);
        r5_m3 <= r4_m3;
        r5_m4 <= r4_m4;
        r5_m5 <= r4_m5;
        r5_t3 <= r4_t3;
        r5_t4 <= r4_t4;
        r5_c0 <= r4_c0;
        r5_c1 <= r4_c1;
        r5_c2 <= r4_c2;
        r5_s  <= r4_s;
        r5_z  <= r4_z;
    end

    assign o_valid  = r_v[4];
    assign o_c0     = r5_c0;
    assign o_c1     = r5_c1;
    assign o_c2     = r5_c2;
    assign o_sat012 = r5_s;
    assign o_zero   = r5_z;
    assign o_m3     = r5_m3;
    assign o_m4     = r5_m4;
    assign o_m5     = r5_m5;
    assign o_t3     = r5_t3;
    assign o_t4     = r5_t4;
    assign o_t5     = r5_t5;
endmodule
`default_nettype wire

// ===== rtl/qmj_div.sv =====
// rounding divider, one quotient bit per cycle, with clipping to 48 bits
`default_nettype none
module qmj_div
    import qmj_pkg::*;
#(
    parameter int MW = 96,
    parameter int DW = 60,
    parameter int SH = 31
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic signed [MW-1:0] i_num,
    input  wire logic [DW-1:0]     i_den,
    output logic                   o_done,
    output logic signed [OUT_W-1:0] o_q,
    output logic                   o_sat
);
    localparam int N2W = MW + SH + 2;
    localparam int XW  = qmj_max(N2W, DW + 1 + QB);
    localparam int CW  = $clog2(QB);

    logic [N2W-1:0] r_n2;
    logic [DW:0]    r_d2, r_rem;
    logic [QB-1:0]  r_low, r_q;
    logic [CW-1:0]  r_cnt;
    logic           r_neg, r_ovf, r_prep, r_run, r_done;

    logic [MW-1:0]  w_mag;
    logic [XW-1:0]  w_nx, w_dx;
    logic [DW+1:0]  w_sh, w_diff;
    logic [QB-1:0]  w_neg_q;

    always_comb begin
        w_mag   = i_num[MW-1] ? MW'(-i_num) : MW'(i_num);
        w_nx    = XW'(r_n2);
        w_dx    = XW'(r_d2) << QB;
        w_sh    = {r_rem, r_low[QB-1]};
        w_diff  = w_sh - {1'b0, r_d2};
        w_neg_q = -r_q;
        // clip against the limit of the result's sign
        if (r_ovf || (r_neg ? (r_q > (QB'(1) << (OUT_W - 1))) :
                              (r_q > ((QB'(1) << (OUT_W - 1)) - 1'b1)))) begin
            o_sat = 1'b1;
            o_q   = r_neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            o_sat = 1'b0;
            o_q   = r_neg ? w_neg_q[OUT_W-1:0] : r_q[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep <= 1'b0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_prep <= i_start;
            r_done <= r_run && (r_cnt == CW'(QB - 1));
            if (r_prep) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QB - 1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // round half away: (2|n| + d) / 2d
            r_n2  <= ((N2W'(w_mag) << SH) << 1) + N2W'(i_den);
            r_d2  <= {i_den, 1'b0};
            r_neg <= i_num[MW-1];
        end
        if (r_prep) begin
            r_ovf <= (w_nx >= w_dx);
            r_rem <= w_nx[QB+DW:QB];
            r_low <= r_n2[QB-1:0];
        end else if (r_run) begin
            r_low <= {r_low[QB-2:0], 1'b0};
            if (!w_diff[DW+1]) begin
                r_rem <= w_diff[DW:0];
                r_q   <= {r_q[QB-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DW:0];
                r_q   <= {r_q[QB-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

// ===== rtl/qmj_back.sv =====
// back end: three dividers run side by side, result register
`default_nettype none
module qmj_back
    import qmj_pkg::*;
#(
    parameter int F  = 16,
    parameter int MW = 96
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_pop,
    input  wire logic signed [OUT_W-1:0] i_c0,
    input  wire logic signed [OUT_W-1:0] i_c1,
    input  wire logic signed [OUT_W-1:0] i_c2,
    input  wire logic              i_sat012,
    input  wire logic              i_zero,
    input  wire logic signed [MW-1:0] i_m3,
    input  wire logic signed [MW-1:0] i_m4,
    input  wire logic signed [MW-1:0] i_m5,
    input  wire logic [3*T_W-1:0]  i_t3,
    input  wire logic [4*T_W-1:0]  i_t4,
    input  wire logic [5*T_W-1:0]  i_t5,
    output logic                   o_valid,
    output t_qmj_out               o_result
);
    t_bk_state r_state, n_state;
    logic      w_start;

    logic signed [OUT_W-1:0] r_c0, r_c1, r_c2;
    logic      r_s, r_z, r_valid;
    t_qmj_out  r_res;

    logic                    d3_done, d4_done, d5_done;
    logic signed [OUT_W-1:0] d3_q, d4_q, d5_q;
    logic                    d3_sat, d4_sat, d5_sat;

    always_comb begin
        n_state = r_state;
        w_start = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    w_start = 1'b1;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (d3_done) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == BK_RUN) && d3_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_c0 <= i_c0;
            r_c1 <= i_c1;
            r_c2 <= i_c2;
            r_s  <= i_sat012;
            r_z  <= i_zero;
        end
        if (d3_done) begin
            r_res.coef0     <= r_c0;
            r_res.coef1     <= r_c1;
            r_res.coef2     <= r_c2;
            r_res.coef3     <= r_z ? '0 : d3_q;
            r_res.coef4     <= r_z ? '0 : d4_q;
            r_res.coef5     <= r_z ? '0 : d5_q;
            r_res.saturated <= r_s | r_z | d3_sat | d4_sat | d5_sat;
        end
    end

    qmj_div #(.MW(MW), .DW(3*T_W), .SH(31)) u_div3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(i_m3), .i_den(i_t3),
        .o_done(d3_done), .o_q(d3_q), .o_sat(d3_sat)
    );

    qmj_div #(.MW(MW), .DW(4*T_W), .SH(31 + F)) u_div4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(i_m4), .i_den(i_t4),
        .o_done(d4_done), .o_q(d4_q), .o_sat(d4_sat)
    );

    qmj_div #(.MW(MW), .DW(5*T_W), .SH(31 + 2 * F)) u_div5 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(i_m5), .i_den(i_t5),
        .o_done(d5_done), .o_q(d5_q), .o_sat(d5_sat)
    );

    assign o_pop    = w_start;
    assign o_valid  = r_valid & d4_done & d5_done | r_valid & ~(d4_done | d5_done);
    assign o_result = r_res;
endmodule
`default_nettype wire

// ===== rtl/quintic_min_jerk_coeffs.sv =====
// top level: minimum-jerk quintic coefficient generator
`default_nettype none
// Computes the six coefficients of the minimum-jerk quintic joining a start
// state and an end state over duration T. Inputs are signed fixed point with
// IN_FRAC_BITS fraction bits, T is unsigned; coefficients are signed Q16.32,
// rounded to nearest with ties away from zero and clipped to 48 bits, with
// saturated set when any was clipped or T is zero (then coef3..coef5 are 0).
// An item is taken when start is high and busy is low. A five-stage front
// pipeline forms the residual numerators and T^3, T^4, T^5 and drops them in
// an eight-entry queue, so start may be pulsed every cycle until busy rises.
// The back runs three bit-serial dividers side by side: each item holds them
// through operand load, one setup step, 49 quotient steps and the result
// register, and the back takes no new item until the last one is done.
// With the back idle, an item reaches the ports through the five front
// stages, the queue, the dividers and the result register. Each result is
// shown for one cycle with o_valid high and cannot be held off.
module quintic_min_jerk_coeffs
    import qmj_pkg::*;
#(
    parameter int IN_FRAC_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_qmj_in  i_item,
    output logic          busy,
    output logic          o_valid,
    output t_qmj_out      o_result
);
    localparam int MW = qmj_mw(IN_FRAC_BITS);
    localparam int QD = 8;
    localparam int CW = $clog2(QD + 1);

    // one queued job between front and back
    typedef struct packed {
        logic signed [OUT_W-1:0] c0;
        logic signed [OUT_W-1:0] c1;
        logic signed [OUT_W-1:0] c2;
        logic                    sat012;
        logic                    zero;
        logic signed [MW-1:0]    m3;
        logic signed [MW-1:0]    m4;
        logic signed [MW-1:0]    m5;
        logic [3*T_W-1:0]        t3;
        logic [4*T_W-1:0]        t4;
        logic [5*T_W-1:0]        t5;
    } t_job;

    t_job  w_fjob, w_bjob;
    logic  w_take, w_push, w_pop, w_empty, w_full;
    // items accepted but not yet handed to the back; bounds the queue
    logic [CW-1:0] r_cnt;

    assign busy   = (r_cnt == CW'(QD));
    assign w_take = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CW'(w_take) - CW'(w_pop);
        end
    end

    qmj_front #(.F(IN_FRAC_BITS), .MW(MW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_take(w_take), .i_item(i_item),
        .o_valid(w_push),
        .o_c0(w_fjob.c0), .o_c1(w_fjob.c1), .o_c2(w_fjob.c2),
        .o_sat012(w_fjob.sat012), .o_zero(w_fjob.zero),
        .o_m3(w_fjob.m3), .o_m4(w_fjob.m4), .o_m5(w_fjob.m5),
        .o_t3(w_fjob.t3), .o_t4(w_fjob.t4), .o_t5(w_fjob.t5)
    );

    qmj_fifo #(.W($bits(t_job)), .DEPTH(QD)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_data(w_fjob),
        .i_pop(w_pop), .o_data(w_bjob),
        .o_empty(w_empty), .o_full(w_full)
    );

    qmj_back #(.F(IN_FRAC_BITS), .MW(MW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(~w_empty), .o_pop(w_pop),
        .i_c0(w_bjob.c0), .i_c1(w_bjob.c1), .i_c2(w_bjob.c2),
        .i_sat012(w_bjob.sat012), .i_zero(w_bjob.zero),
        .i_m3(w_bjob.m3), .i_m4(w_bjob.m4), .i_m5(w_bjob.m5),
        .i_t3(w_bjob.t3), .i_t4(w_bjob.t4), .i_t5(w_bjob.t5),
        .o_valid(o_valid), .o_result(o_result)
    );

    // queue never overflows thanks to the credit count
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("queue push while full");

    // back only pops what has been accepted
    a_pop_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_cnt != '0)) else $error("pop without outstanding item");

    // results are spaced by the divider loop
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("back-to-back result strobes");
endmodule
`default_nettype wire
